[sv/swfg_pkg.sv]
`timescale 1ns / 1ps

package swfg_pkg;

  localparam int AMOUNT_BITS = 32;
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int DIM_W       = 7;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
  localparam int CELLS       = MAX_WIDTH * MAX_HEIGHT;
  localparam int NEIGH       = 9;
  localparam int CENTER      = 4;
  localparam int CNT_W       = 4;
  localparam int REM_W       = 4;
  localparam int WT_W        = AMOUNT_BITS + 1;
  localparam int LVL_W       = AMOUNT_BITS + 4;
  localparam int DLT_W       = AMOUNT_BITS + 6;
  localparam int DIV_CNT_W   = $clog2(AMOUNT_BITS);

  localparam logic [AMOUNT_BITS-1:0] AMT_MAX = '1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  typedef struct packed {
    logic [1:0]             op;
    logic [COL_BITS-1:0]    cell_x;
    logic [ROW_BITS-1:0]    cell_y;
    logic [AMOUNT_BITS-1:0] write_a;
    logic [AMOUNT_BITS-1:0] write_b;
    logic [AMOUNT_BITS-1:0] write_c;
  } req_t;

  typedef struct packed {
    logic [AMOUNT_BITS-1:0] read_a;
    logic [AMOUNT_BITS-1:0] read_b;
    logic [AMOUNT_BITS-1:0] read_c;
  } rsp_t;

  typedef struct packed {
    logic [AMOUNT_BITS-1:0] a;
    logic [AMOUNT_BITS-1:0] b;
    logic [AMOUNT_BITS-1:0] c;
  } cell_t;

  function automatic logic [AMOUNT_BITS-1:0] sat_add(input logic [AMOUNT_BITS-1:0] acc,
                                                     input logic [LVL_W-1:0] g);
    logic [LVL_W:0] sum;
    sum = {{(LVL_W+1-AMOUNT_BITS){1'b0}}, acc} + {1'b0, g};
    if (sum > {{(LVL_W+1-AMOUNT_BITS){1'b0}}, AMT_MAX}) begin
      return AMT_MAX;
    end
    return sum[AMOUNT_BITS-1:0];
  endfunction

  // Address of neighbor n (row-major over the 3x3 window) with wrap at the live edges.
  function automatic logic [ADDR_BITS-1:0] nb_addr(input logic [COL_BITS-1:0] x,
                                                   input logic [ROW_BITS-1:0] y,
                                                   input logic [DIM_W-1:0]    w,
                                                   input logic [DIM_W-1:0]    h,
                                                   input logic [CNT_W-1:0]    n);
    logic [1:0]          dr;
    logic [1:0]          dc;
    logic [COL_BITS-1:0] nx;
    logic [ROW_BITS-1:0] ny;
    case (n)
      4'd0: begin dr = 2'd0; dc = 2'd0; end
      4'd1: begin dr = 2'd0; dc = 2'd1; end
      4'd2: begin dr = 2'd0; dc = 2'd2; end
      4'd3: begin dr = 2'd1; dc = 2'd0; end
      4'd5: begin dr = 2'd1; dc = 2'd2; end
      4'd6: begin dr = 2'd2; dc = 2'd0; end
      4'd7: begin dr = 2'd2; dc = 2'd1; end
      4'd8: begin dr = 2'd2; dc = 2'd2; end
      default: begin dr = 2'd1; dc = 2'd1; end
    endcase
    case (dr)
      2'd0: ny = (y == '0) ? ROW_BITS'(h - DIM_W'(1)) : y - ROW_BITS'(1);
      2'd2: ny = (DIM_W'(y) + DIM_W'(1) == h) ? '0 : y + ROW_BITS'(1);
      default: ny = y;
    endcase
    case (dc)
      2'd0: nx = (x == '0) ? COL_BITS'(w - DIM_W'(1)) : x - COL_BITS'(1);
      2'd2: nx = (DIM_W'(x) + DIM_W'(1) == w) ? '0 : x + COL_BITS'(1);
      default: nx = x;
    endcase
    return {ny, nx};
  endfunction

endpackage

[sv/sediment_water_fill_grouping.sv]
// A write item does not hold the request side. A read item holds the request side until its
// result is loaded from ST_RDOUT, which waits while a stalled result is still held.
// A step item holds the request side until the whole W x H live grid is done: one sorter,
// leveler and bit-serial divider are shared by all cells and all three cell kinds.
// The next-state store is cleared cell by cell at the start of a step and copied back at its end.
// Reset is synchronous: the sequencer goes idle, the result register empties and both grid
// dimensions return to 64; stored cells hold no defined value until written.
`timescale 1ns / 1ps

module sediment_water_fill_grouping import swfg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RDOUT = 9'b000000010,
    ST_CLR   = 9'b000000100,
    ST_GATH  = 9'b000001000,
    ST_SORT  = 9'b000010000,
    ST_FILL  = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_DIST  = 9'b010000000,
    ST_COPY  = 9'b100000000
  } state_t;

  state_t state;

  logic [DIM_W-1:0]    grid_width;
  logic [DIM_W-1:0]    grid_height;
  logic [DIM_W-1:0]    live_w;
  logic [DIM_W-1:0]    live_h;
  logic [COL_BITS-1:0] cx;
  logic [ROW_BITS-1:0] cy;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    gi;
  logic [CNT_W-1:0]    ns;
  logic                ph;
  logic [1:0]          kind;

  logic signed [WT_W-1:0]  wt [NEIGH][3];
  logic signed [WT_W-1:0]  s [NEIGH];
  logic signed [WT_W-1:0]  s_next [NEIGH];
  logic                    gt [NEIGH];
  logic signed [WT_W-1:0]  sort_v;
  logic [AMOUNT_BITS-1:0]  own [3];
  logic [AMOUNT_BITS-1:0]  amt;
  logic signed [LVL_W-1:0] lowest;
  logic signed [LVL_W-1:0] lvl [3];
  logic [REM_W-1:0]        rem [3];
  logic [LVL_W-1:0]        gain [3];
  logic [LVL_W-1:0]        gain_next [3];
  logic signed [LVL_W-1:0] gdiff [3];
  logic signed [LVL_W-1:0] diff;
  logic [DLT_W-1:0]        delta;
  logic                    fill_stop;

  logic [ADDR_BITS-1:0] hold_addr;
  logic                 hold_inside;
  logic [ADDR_BITS-1:0] req_addr;
  logic                 req_inside;
  logic [ADDR_BITS-1:0] cur_addr;
  logic [ADDR_BITS-1:0] nb;
  logic                 accept;
  logic                 rsp_load;
  logic                 last_x;
  logic                 last_y;

  logic                 sed_we;
  logic [ADDR_BITS-1:0] sed_waddr;
  cell_t                sed_wdata;
  logic [ADDR_BITS-1:0] sed_raddr;
  cell_t                sed_rdata;
  logic                 nxt_we;
  logic [ADDR_BITS-1:0] nxt_waddr;
  cell_t                nxt_wdata;
  logic [ADDR_BITS-1:0] nxt_raddr;
  cell_t                nxt_rdata;

  logic                   div_start;
  logic                   div_done;
  logic [AMOUNT_BITS-1:0] div_quo;
  logic [REM_W-1:0]       div_rmd;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_load  = (state == ST_RDOUT) && (!rsp_valid || !rsp_stall);

  assign live_w = (grid_width < DIM_W'(3)) ? DIM_W'(3) :
                  (grid_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : grid_width;
  assign live_h = (grid_height < DIM_W'(3)) ? DIM_W'(3) :
                  (grid_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : grid_height;

  assign req_addr   = {req.cell_y, req.cell_x};
  assign req_inside = (DIM_W'(req.cell_x) < live_w) && (DIM_W'(req.cell_y) < live_h);
  assign cur_addr   = {cy, cx};
  assign nb         = nb_addr(cx, cy, live_w, live_h, n);
  assign last_x     = (DIM_W'(cx) == live_w - DIM_W'(1));
  assign last_y     = (DIM_W'(cy) == live_h - DIM_W'(1));
  assign gi         = n - CNT_W'(1);
  assign ns         = (n >= CNT_W'(NEIGH)) ? CNT_W'(CENTER) : n;

  swfg_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_sed_ram (
    .clk   (clk),
    .we    (sed_we),
    .waddr (sed_waddr),
    .wdata (sed_wdata),
    .raddr (sed_raddr),
    .rdata (sed_rdata)
  );

  swfg_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  swfg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (amt),
    .divisor  (n),
    .done     (div_done),
    .quo      (div_quo),
    .rmd      (div_rmd)
  );

  always_comb begin
    case (state)
      ST_IDLE:  sed_raddr = req_addr;
      ST_RDOUT: sed_raddr = hold_addr;
      default:  sed_raddr = nb;
    endcase
    sed_we    = (accept && req.op == OP_WRITE && req_inside) || (state == ST_COPY && ph);
    sed_waddr = (state == ST_COPY) ? cur_addr : req_addr;
    sed_wdata = (state == ST_COPY) ? nxt_rdata : cell_t'{req.write_a, req.write_b, req.write_c};

    nxt_raddr = (state == ST_COPY) ? cur_addr : nb;
    nxt_we    = (state == ST_CLR) || (state == ST_DIST && ph);
    nxt_waddr = (state == ST_DIST) ? nb : cur_addr;
    if (state == ST_CLR) begin
      nxt_wdata = '0;
    end else begin
      nxt_wdata.a = sat_add(nxt_rdata.a, gain[0]);
      nxt_wdata.b = sat_add(nxt_rdata.b, gain[1]);
      nxt_wdata.c = sat_add(nxt_rdata.c, gain[2]);
    end
  end

  // Insertion of one weight per cycle into the sorted row s.
  always_comb begin
    sort_v = wt[ns][kind];
    for (int j = 0; j < NEIGH; j++) begin
      gt[j] = (CNT_W'(j) < n) && (s[j] > sort_v);
    end
    s_next[0] = (gt[0] || n == '0) ? sort_v : s[0];
    for (int j = 1; j < NEIGH; j++) begin
      if (gt[j-1]) begin
        s_next[j] = s[j-1];
      end else if (gt[j] || CNT_W'(j) == n) begin
        s_next[j] = sort_v;
      end else begin
        s_next[j] = s[j];
      end
    end
  end

  always_comb begin
    diff      = LVL_W'(s[ns]) - lowest;
    delta     = DLT_W'($unsigned(diff)) * DLT_W'(n);
    fill_stop = (n == CNT_W'(NEIGH)) || (delta > DLT_W'(amt));
    div_start = (state == ST_FILL) && fill_stop && (amt != '0);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gdiff[k]     = lvl[k] - LVL_W'(wt[ns][k]);
      gain_next[k] = (gdiff[k] > 0) ? LVL_W'($unsigned(gdiff[k])) : '0;
      if (n == CNT_W'(CENTER)) begin
        gain_next[k] = gain_next[k] + LVL_W'(rem[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rsp_valid   <= 1'b0;
      grid_width  <= DIM_W'(MAX_WIDTH);
      grid_height <= DIM_W'(MAX_HEIGHT);
      n           <= '0;
      ph          <= 1'b0;
      kind        <= '0;
      cx          <= '0;
      cy          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_WIDTH) begin
          grid_width <= cfg_data;
        end else if (cfg_index == REG_GRID_HEIGHT) begin
          grid_height <= cfg_data;
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.op == OP_STEP) begin
              state <= ST_CLR;
              cx    <= '0;
              cy    <= '0;
            end else if (req.op == OP_READ) begin
              hold_addr   <= req_addr;
              hold_inside <= req_inside;
              state       <= ST_RDOUT;
            end
          end
        end
        ST_RDOUT: begin
          if (rsp_load) begin
            rsp   <= hold_inside ? rsp_t'(sed_rdata) : '0;
            state <= ST_IDLE;
          end
        end
        ST_CLR: begin
          if (last_x) begin
            cx <= '0;
            cy <= last_y ? '0 : cy + ROW_BITS'(1);
            if (last_y) begin
              state <= ST_GATH;
              n     <= '0;
            end
          end else begin
            cx <= cx + COL_BITS'(1);
          end
        end
        ST_GATH: begin
          // Read data of the neighbor addressed in the previous cycle.
          if (n != '0) begin
            wt[gi][0] <= $signed({1'b0, sed_rdata.b});
            wt[gi][1] <= $signed({1'b0, sed_rdata.a}) - $signed({1'b0, sed_rdata.c});
            wt[gi][2] <= -$signed({1'b0, sed_rdata.b});
            if (gi == CNT_W'(CENTER)) begin
              own[0] <= sed_rdata.a;
              own[1] <= sed_rdata.b;
              own[2] <= sed_rdata.c;
            end
          end
          if (n == CNT_W'(NEIGH)) begin
            state <= ST_SORT;
            n     <= '0;
            kind  <= '0;
          end else begin
            n <= n + CNT_W'(1);
          end
        end
        ST_SORT: begin
          s <= s_next;
          if (n == CNT_W'(NEIGH - 1)) begin
            state  <= ST_FILL;
            n      <= CNT_W'(1);
            lowest <= LVL_W'(s_next[0]);
            amt    <= own[kind];
          end else begin
            n <= n + CNT_W'(1);
          end
        end
        ST_FILL: begin
          if (fill_stop) begin
            if (amt != '0) begin
              state <= ST_DIV;
            end else begin
              lvl[kind] <= lowest;
              rem[kind] <= '0;
              n         <= '0;
              if (kind == 2'd2) begin
                state <= ST_DIST;
                ph    <= 1'b0;
              end else begin
                kind  <= kind + 2'd1;
                state <= ST_SORT;
              end
            end
          end else begin
            amt    <= amt - delta[AMOUNT_BITS-1:0];
            lowest <= LVL_W'(s[ns]);
            n      <= n + CNT_W'(1);
          end
        end
        ST_DIV: begin
          if (div_done) begin
            lvl[kind] <= lowest + LVL_W'(div_quo);
            rem[kind] <= div_rmd;
            n         <= '0;
            if (kind == 2'd2) begin
              state <= ST_DIST;
              ph    <= 1'b0;
            end else begin
              kind  <= kind + 2'd1;
              state <= ST_SORT;
            end
          end
        end
        ST_DIST: begin
          if (!ph) begin
            gain <= gain_next;
            ph   <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (n == CNT_W'(NEIGH - 1)) begin
              n <= '0;
              if (last_x) begin
                cx <= '0;
                cy <= last_y ? '0 : cy + ROW_BITS'(1);
              end else begin
                cx <= cx + COL_BITS'(1);
              end
              state <= (last_x && last_y) ? ST_COPY : ST_GATH;
            end else begin
              n <= n + CNT_W'(1);
            end
          end
        end
        ST_COPY: begin
          ph <= !ph;
          if (ph) begin
            if (last_x) begin
              cx <= '0;
              cy <= last_y ? '0 : cy + ROW_BITS'(1);
              if (last_y) begin
                state <= ST_IDLE;
              end
            end else begin
              cx <= cx + COL_BITS'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/swfg_ram.sv]
`timescale 1ns / 1ps

module swfg_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/swfg_div.sv]
`timescale 1ns / 1ps

module swfg_div import swfg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [AMOUNT_BITS-1:0] dividend,
  input  logic [CNT_W-1:0]       divisor,
  output logic                   done,
  output logic [AMOUNT_BITS-1:0] quo,
  output logic [REM_W-1:0]       rmd
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [REM_W:0]       shifted;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rmd, quo[AMOUNT_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rmd  <= '0;
      end else if (busy) begin
        if (shifted >= {1'b0, divisor}) begin
          rmd <= REM_W'(shifted - {1'b0, divisor});
          quo <= {quo[AMOUNT_BITS-2:0], 1'b1};
        end else begin
          rmd <= shifted[REM_W-1:0];
          quo <= {quo[AMOUNT_BITS-2:0], 1'b0};
        end
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(AMOUNT_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/swfg_checker.sv]
`timescale 1ns / 1ps

module swfg_checker import swfg_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input req_t                 req,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input rsp_t                 rsp
);

  logic req_acc;

  assign req_acc = req_valid && !req_stall;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    req_acc && req.op == OP_STEP |=> req_stall)
    else $error("step item did not hold off the request side");

  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    req_acc && req.op == OP_WRITE |=> !req_stall)
    else $error("write item took more than one cycle");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    req_acc && req.op == OP_READ && !rsp_valid |=> ##1 rsp_valid)
    else $error("read item gave no result in time");

endmodule

bind sediment_water_fill_grouping swfg_checker u_swfg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
